// ----- sv/rsa_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rsa_pkg
// Types and codes shared by the RPN stack ALU: operation and status codes,
// sequencer states and the request/response bundle of the arithmetic unit.
// ----------------------------------------------------------------------------
package rsa_pkg;

  localparam int DATA_W   = 32;
  localparam int FUNC_W   = 3;
  localparam int STATUS_W = 3;
  localparam int DEPTH_W  = 5;

  // Operation carried with each input beat
  typedef enum logic [FUNC_W-1:0] {
    FN_PUSH = 3'd0,
    FN_ADD  = 3'd1,
    FN_SUB  = 3'd2,
    FN_MUL  = 3'd3,
    FN_DIV  = 3'd4
  } func_t;

  // Status reported with each output beat
  typedef enum logic [STATUS_W-1:0] {
    ST_OK        = 3'd0,
    ST_NEEDTWO   = 3'd1,
    ST_OVERFLOW  = 3'd2,
    ST_UNDERFLOW = 3'd3,
    ST_DIVZERO   = 3'd4,
    ST_FULL      = 3'd5
  } status_t;

  // Top-level sequencer
  typedef enum logic [2:0] {
    S_IDLE,
    S_RD_R,
    S_RD_L,
    S_OPS,
    S_WAIT,
    S_TOP,
    S_TOP_W,
    S_OUT
  } ctl_state_t;

  // Arithmetic unit sequencer
  typedef enum logic [1:0] {
    U_IDLE,
    U_MUL,
    U_DIV,
    U_FIX
  } alu_state_t;

  typedef struct packed {
    logic                     start;
    func_t                    op;
    logic signed [DATA_W-1:0] a;
    logic signed [DATA_W-1:0] b;
  } alu_req_t;

  typedef struct packed {
    logic              done;
    status_t           status;
    logic [DATA_W-1:0] result;
  } alu_rsp_t;

endpackage

// ----- sv/rsa_ram.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rsa_ram
// Generic simple dual-port RAM: one write port, one read port with
// registered read data.
// ----------------------------------------------------------------------------
module rsa_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write and registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- sv/rsa_alu.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rsa_alu
// Iterative signed 32-bit arithmetic unit built around one shared 34-bit
// adder/subtractor: add and subtract straight from idle, shift-add multiply and
// restoring divide over 32 steps plus one sign-fix step.
// ----------------------------------------------------------------------------
module rsa_alu
  import rsa_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  alu_req_t req,
  output alu_rsp_t rsp
);

  alu_state_t        state, state_next;
  logic [DATA_W-1:0] hi, hi_next;      // product high half or remainder
  logic [DATA_W-1:0] lo, lo_next;      // multiplier/product low or quotient
  logic [DATA_W-1:0] m, m_next;        // multiplicand or divisor magnitude
  logic              neg, neg_next;
  logic              is_div, is_div_next;
  logic [4:0]        step, step_next;
  alu_rsp_t          rsp_next;

  // Shared adder
  logic [DATA_W+1:0] add_x, add_y, add_s;
  logic              add_sub;

  logic [DATA_W-1:0] mag_a, mag_b, prod_hi;

  assign add_s = add_sub ? (add_x - add_y) : (add_x + add_y);

  assign mag_a   = req.a[DATA_W-1] ? (~req.a + 32'd1) : req.a;
  assign mag_b   = req.b[DATA_W-1] ? (~req.b + 32'd1) : req.b;
  assign prod_hi = is_div ? '0 : hi;

  // Sequencer register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= U_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Datapath and response registers
  always_ff @(posedge clk) begin
    hi         <= hi_next;
    lo         <= lo_next;
    m          <= m_next;
    neg        <= neg_next;
    is_div     <= is_div_next;
    step       <= step_next;
    rsp.status <= rsp_next.status;
    rsp.result <= rsp_next.result;
    if (rst) begin
      rsp.done <= 1'b0;
    end else begin
      rsp.done <= rsp_next.done;
    end
  end

  // Next state and shared adder steering
  always_comb begin
    state_next      = state;
    hi_next         = hi;
    lo_next         = lo;
    m_next          = m;
    neg_next        = neg;
    is_div_next     = is_div;
    step_next       = step;
    rsp_next.done   = 1'b0;
    rsp_next.status = rsp.status;
    rsp_next.result = rsp.result;
    add_x           = '0;
    add_y           = '0;
    add_sub         = 1'b0;
    unique case (state)
      U_IDLE: begin
        if (req.start) begin
          neg_next  = req.a[DATA_W-1] ^ req.b[DATA_W-1];
          step_next = '0;
          hi_next   = '0;
          unique case (req.op)
            FN_ADD, FN_SUB: begin
              add_x           = {{2{req.a[DATA_W-1]}}, req.a};
              add_y           = {{2{req.b[DATA_W-1]}}, req.b};
              add_sub         = (req.op == FN_SUB);
              rsp_next.done   = 1'b1;
              rsp_next.result = add_s[DATA_W-1:0];
              if (add_s[DATA_W+1:DATA_W-1] == 3'b000 ||
                  add_s[DATA_W+1:DATA_W-1] == 3'b111) begin
                rsp_next.status = ST_OK;
              end else if (add_s[DATA_W+1]) begin
                rsp_next.status = ST_UNDERFLOW;
              end else begin
                rsp_next.status = ST_OVERFLOW;
              end
            end
            FN_MUL: begin
              lo_next     = mag_b;
              m_next      = mag_a;
              is_div_next = 1'b0;
              state_next  = U_MUL;
            end
            FN_DIV: begin
              if (req.b == '0) begin
                rsp_next.done   = 1'b1;
                rsp_next.status = ST_DIVZERO;
              end else begin
                lo_next     = mag_a;
                m_next      = mag_b;
                is_div_next = 1'b1;
                state_next  = U_DIV;
              end
            end
            default: begin
              rsp_next.done   = 1'b1;
              rsp_next.status = ST_OK;
            end
          endcase
        end
      end
      U_MUL: begin
        // Add multiplicand on a set bit, shift product right
        add_x     = {2'b00, hi};
        add_y     = lo[0] ? {2'b00, m} : '0;
        hi_next   = add_s[DATA_W:1];
        lo_next   = {add_s[0], lo[DATA_W-1:1]};
        step_next = step + 5'd1;
        if (step == 5'd31) begin
          state_next = U_FIX;
        end
      end
      U_DIV: begin
        // Trial subtract, keep the difference when it does not borrow
        add_x   = {1'b0, hi, lo[DATA_W-1]};
        add_y   = {2'b00, m};
        add_sub = 1'b1;
        if (!add_s[DATA_W+1]) begin
          hi_next = add_s[DATA_W-1:0];
        end else begin
          hi_next = {hi[DATA_W-2:0], lo[DATA_W-1]};
        end
        lo_next   = {lo[DATA_W-2:0], ~add_s[DATA_W+1]};
        step_next = step + 5'd1;
        if (step == 5'd31) begin
          state_next = U_FIX;
        end
      end
      U_FIX: begin
        // Apply sign and range-check the magnitude
        add_x           = '0;
        add_y           = {2'b00, lo};
        add_sub         = 1'b1;
        rsp_next.done   = 1'b1;
        rsp_next.result = neg ? add_s[DATA_W-1:0] : lo;
        if (neg) begin
          if (prod_hi != '0 || (lo[DATA_W-1] && lo[DATA_W-2:0] != '0)) begin
            rsp_next.status = ST_UNDERFLOW;
          end else begin
            rsp_next.status = ST_OK;
          end
        end else begin
          if (prod_hi != '0 || lo[DATA_W-1]) begin
            rsp_next.status = ST_OVERFLOW;
          end else begin
            rsp_next.status = ST_OK;
          end
        end
        state_next = U_IDLE;
      end
      default: begin
        state_next = U_IDLE;
      end
    endcase
  end

endmodule

// ----- sv/rpn_stack_alu.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rpn_stack_alu
// Reverse-Polish integer stack ALU with a RAM-backed stack and an iterative
// arithmetic unit.
// ----------------------------------------------------------------------------
// Usage:
//   Input beat: s_tuser carries the operation (push, add, sub, mul, div),
//   s_tdata the signed value to push. The second entry from the top is the
//   left operand, the top entry the right; the in-range result replaces both.
//   Output beat: m_tuser carries the status, m_tdata the new top of stack
//   (zero when empty) and the new depth. One output beat per input beat.
//   Arithmetic operations read the top entry, then the second entry, start
//   the arithmetic unit and wait for its result; multiply and divide run
//   its 32 shift-add or restoring steps plus its sign-fix step. Every
//   operation then reads the new top entry from the stack RAM (one
//   registered read port), skipped when the stack is left empty.
//   s_tready is high only while the sequencer is idle; one finished result
//   may wait in the output register while the next beat is taken in. If the
//   receiver stalls with a result still held, the sequencer waits before
//   loading the following result.
//   Reset empties the stack and drops any held result; no clearing pass.
// ----------------------------------------------------------------------------
module rpn_stack_alu
  import rsa_pkg::*;
#(
  parameter int STACK_DEPTH = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [2:0]  s_tuser,   // [2:0] func
  input  logic [31:0] s_tdata,   // [31:0] value
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [2:0]  m_tuser,   // [2:0] status
  output logic [39:0] m_tdata    // [31:0] top_value, [36:32] depth, rest zero
);

  localparam int AW    = $clog2(STACK_DEPTH);
  localparam int CNT_W = $clog2(STACK_DEPTH + 1);

  ctl_state_t        state, state_next;
  logic [CNT_W-1:0]  count, count_next;
  logic [CNT_W-1:0]  cnt_m1, cnt_m2;
  func_t             op, op_next;
  status_t           status, status_next;
  logic [DATA_W-1:0] right, right_next;
  logic [DATA_W-1:0] top, top_next;
  logic              out_load;
  logic              s_fire;

  logic              ram_we;
  logic [AW-1:0]     ram_waddr, ram_raddr;
  logic [DATA_W-1:0] ram_wdata, ram_rdata;

  alu_req_t          alu_req;
  alu_rsp_t          alu_rsp;

  assign cnt_m1   = count - CNT_W'(1);
  assign cnt_m2   = count - CNT_W'(2);
  assign s_tready = (state == S_IDLE);
  assign s_fire   = s_tvalid && s_tready;

  rsa_ram #(
    .WIDTH (DATA_W),
    .DEPTH (STACK_DEPTH)
  ) u_stack (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  rsa_alu u_alu (
    .clk (clk),
    .rst (rst),
    .req (alu_req),
    .rsp (alu_rsp)
  );

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      count    <= '0;
      m_tvalid <= 1'b0;
    end else begin
      state <= state_next;
      count <= count_next;
      if (out_load) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    op     <= op_next;
    status <= status_next;
    right  <= right_next;
    top    <= top_next;
    if (out_load) begin
      m_tuser <= status;
      m_tdata <= {3'b000, DEPTH_W'(count), top};
    end
  end

  // Sequencer
  always_comb begin
    state_next    = state;
    count_next    = count;
    op_next       = op;
    status_next   = status;
    right_next    = right;
    top_next      = top;
    out_load      = 1'b0;
    ram_we        = 1'b0;
    ram_waddr     = count[AW-1:0];
    ram_wdata     = s_tdata;
    ram_raddr     = cnt_m1[AW-1:0];
    alu_req.start = 1'b0;
    alu_req.op    = op;
    alu_req.a     = ram_rdata;
    alu_req.b     = right;
    unique case (state)
      S_IDLE: begin
        if (s_fire) begin
          op_next     = func_t'(s_tuser);
          status_next = ST_OK;
          state_next  = S_TOP;
          unique case (func_t'(s_tuser))
            FN_PUSH: begin
              if (count == CNT_W'(STACK_DEPTH)) begin
                status_next = ST_FULL;
              end else begin
                ram_we     = 1'b1;
                count_next = count + CNT_W'(1);
              end
            end
            FN_ADD, FN_SUB, FN_MUL, FN_DIV: begin
              if (count < CNT_W'(2)) begin
                status_next = ST_NEEDTWO;
              end else begin
                state_next = S_RD_R;
              end
            end
            default: begin
              status_next = ST_OK;
            end
          endcase
        end
      end
      S_RD_R: begin
        // Fetch top entry
        ram_raddr  = cnt_m1[AW-1:0];
        state_next = S_RD_L;
      end
      S_RD_L: begin
        // Fetch second entry, hold top as right operand
        ram_raddr  = cnt_m2[AW-1:0];
        right_next = ram_rdata;
        state_next = S_OPS;
      end
      S_OPS: begin
        alu_req.start = 1'b1;
        state_next    = S_WAIT;
      end
      S_WAIT: begin
        // Drop both operands, push result when in range
        if (alu_rsp.done) begin
          status_next = alu_rsp.status;
          count_next  = cnt_m2;
          ram_waddr   = cnt_m2[AW-1:0];
          ram_wdata   = alu_rsp.result;
          if (alu_rsp.status == ST_OK) begin
            ram_we     = 1'b1;
            count_next = cnt_m1;
          end
          state_next = S_TOP;
        end
      end
      S_TOP: begin
        ram_raddr = cnt_m1[AW-1:0];
        if (count == '0) begin
          top_next   = '0;
          state_next = S_OUT;
        end else begin
          state_next = S_TOP_W;
        end
      end
      S_TOP_W: begin
        top_next   = ram_rdata;
        state_next = S_OUT;
      end
      S_OUT: begin
        // Load the output register once it is free
        if (!m_tvalid || m_tready) begin
          out_load   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule
